FILE: rtl/core/bcc_pkg.sv
// bcc_pkg: shared types and constants for the button click classifier
// no dependencies; imported by button_click_classifier and bcc_checker

package bcc_pkg;

  // tick rate default for the top level parameter
  localparam int TICKS_PER_SECOND_DEF = 500;

  // configuration reset values
  localparam logic [15:0] RST_LONG_PRESS   = 16'd750;
  localparam logic [15:0] RST_DOUBLE_WIN   = 16'd100;
  localparam logic [15:0] RST_TIMEOUT      = 16'd30;

  // state reset values
  localparam logic [15:0] RST_HISTORY      = 16'h0001;
  localparam logic [15:0] RST_RELEASE_GAP  = 16'd10000;

  // history patterns
  localparam logic [15:0] PAT_PRESS        = 16'h8000;
  localparam logic [15:0] PAT_RELEASE      = 16'h7fff;
  localparam logic [15:0] PAT_HELD         = 16'h0000;

  // saturation limits
  localparam logic [31:0] ACT_MAX          = 32'hffff_ffff;
  localparam logic [15:0] GAP_MAX          = 16'hffff;

  // apb register address width and index codes
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_DOUBLE_WIN = 2'd1,
    REG_TIMEOUT    = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  // click event codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } click_ev_t;

  // payload of one input transaction
  typedef struct packed {
    logic switch_level;
    logic activity_reset;
  } in_item_t;

  // payload of one result transaction
  typedef struct packed {
    logic [1:0] click_event;
    logic       power_off;
  } out_item_t;

endpackage

FILE: rtl/core/button_click_classifier.sv
// button_click_classifier: debounced click detector with power-off timer
// depends on bcc_pkg; checked by bcc_checker (bound from its own file)
//
//  channel | ports                                   | role
//  --------+-----------------------------------------+---------------------------
//  in      | in_valid, in_ready, in_data             | one poll tick per transaction
//  out     | out_valid, out_ready, out_data          | one click/power result per tick
//  cfg     | psel penable pwrite paddr pwdata prdata | apb registers at 0x0,0x4,0x8
//
// one tick is taken per clock while in_ready is high; its result appears in the
// output register the cycle after acceptance. the state update is a single pass of
// compare and increment logic. in_ready stays high while the output register is
// empty or being drained, so a stall on out only holds the input when a result waits.
// rst_n (synchronous) restores the registers and state to their reset values.
// the power-off limit is timeout times the tick rate, registered on write.

module button_click_classifier
  import bcc_pkg::*;
#(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // tick input
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  // result output
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int LIMIT_W = 16 + $clog2(TICKS_PER_SECOND + 1);
  localparam logic [LIMIT_W-1:0] RST_LIMIT =
    LIMIT_W'(32'(RST_TIMEOUT) * 32'(TICKS_PER_SECOND));

  // configuration registers
  logic [15:0]        long_press_r;
  logic [15:0]        double_win_r;
  logic [15:0]        timeout_r;
  logic [LIMIT_W-1:0] limit_r;

  // block state
  logic [15:0] history_r,  history_nxt;
  logic        suppress_r, suppress_nxt;
  logic [31:0] activity_r, activity_nxt;
  logic [15:0] gap_r,      gap_nxt;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  logic     in_fire;
  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic [31:0] act_inc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  // register writes; the limit product is registered here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= RST_LONG_PRESS;
      double_win_r <= RST_DOUBLE_WIN;
      timeout_r    <= RST_TIMEOUT;
      limit_r      <= RST_LIMIT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LONG_PRESS: long_press_r <= pwdata[15:0];
        REG_DOUBLE_WIN: double_win_r <= pwdata[15:0];
        REG_TIMEOUT: begin
          timeout_r <= pwdata[15:0];
          limit_r   <= LIMIT_W'(pwdata[15:0]) * LIMIT_W'(TICKS_PER_SECOND);
        end
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_LONG_PRESS: prdata = {16'h0000, long_press_r};
      REG_DOUBLE_WIN: prdata = {16'h0000, double_win_r};
      REG_TIMEOUT:    prdata = {16'h0000, timeout_r};
      default:        prdata = 32'h0000_0000;
    endcase
  end

  // handshake
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // tick update: clear, increment, shift, pattern test, power-off compare
  always_comb begin
    act_inc      = in_data.activity_reset ? 32'd0 : activity_r;
    if (act_inc != ACT_MAX) begin
      act_inc = act_inc + 32'd1;
    end
    activity_nxt = act_inc;
    gap_nxt      = (gap_r < GAP_MAX) ? gap_r + 16'd1 : gap_r;
    history_nxt  = {history_r[14:0], in_data.switch_level};
    suppress_nxt = suppress_r;
    out_data_nxt.click_event = EV_NONE;

    if (history_nxt == PAT_PRESS) begin
      if (gap_nxt < double_win_r) begin
        out_data_nxt.click_event = EV_DOUBLE;
        suppress_nxt = 1'b1;
      end
      activity_nxt = 32'd0;
    end else if (history_nxt == PAT_RELEASE) begin
      activity_nxt = 32'd0;
      gap_nxt      = 16'd0;
      if (!suppress_r) begin
        out_data_nxt.click_event = EV_SINGLE;
      end
      suppress_nxt = 1'b0;
    end else if (history_nxt == PAT_HELD) begin
      if ((act_inc > 32'(long_press_r)) && !suppress_r) begin
        out_data_nxt.click_event = EV_LONG;
        suppress_nxt = 1'b1;
      end
    end

    out_data_nxt.power_off = activity_nxt > 32'(limit_r);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_r  <= RST_HISTORY;
      suppress_r <= 1'b1;
      activity_r <= 32'd0;
      gap_r      <= RST_RELEASE_GAP;
    end else if (in_fire) begin
      history_r  <= history_nxt;
      suppress_r <= suppress_nxt;
      activity_r <= activity_nxt;
      gap_r      <= gap_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: rtl/core/bcc_checker.sv
// bcc_checker: port-level assertions for button_click_classifier
// depends on bcc_pkg; bound to the top level at the end of this file

module bcc_checker
  import bcc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      pready
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty output register never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // every accepted tick yields a result in the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result");

  // config port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);
